// ===== rtl/add_sub_paren_expression_eval_defines.svh =====
// Assertion macros used by the checker file.
`ifndef ADD_SUB_PAREN_EXPRESSION_EVAL_DEFINES_SVH
`define ADD_SUB_PAREN_EXPRESSION_EVAL_DEFINES_SVH

// Checked at every clock edge, reset included.
`define ASEP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while reset is released.
`define ASEP_ASSERT_RUN(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`endif

// ===== rtl/asep_pkg.sv =====
package asep_pkg;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_DIGIT,
		OP_PLUS,
		OP_MINUS,
		OP_OPEN,
		OP_CLOSE
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] digit;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [31:0] sum;
		logic        sign;
	} frame_t;

	localparam int FRAME_W = $bits(frame_t);

endpackage

// ===== rtl/asep_front.sv =====
module asep_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        char_code,
	input  logic              is_last,
	output logic              q_valid,
	input  logic              q_ready,
	output asep_pkg::item_t   q_item
);

	logic [7:0] offset;

	assign offset   = char_code - asep_pkg::CH_ZERO;
	assign q_valid  = in_valid;
	assign in_ready = q_ready;

	always_comb begin
		q_item.op    = asep_pkg::OP_NONE;
		q_item.digit = offset[3:0];
		q_item.last  = is_last;
		unique case (char_code) inside
			[asep_pkg::CH_ZERO:asep_pkg::CH_NINE]: q_item.op = asep_pkg::OP_DIGIT;
			asep_pkg::CH_PLUS:  q_item.op = asep_pkg::OP_PLUS;
			asep_pkg::CH_MINUS: q_item.op = asep_pkg::OP_MINUS;
			asep_pkg::CH_OPEN:  q_item.op = asep_pkg::OP_OPEN;
			asep_pkg::CH_CLOSE: q_item.op = asep_pkg::OP_CLOSE;
			asep_pkg::CH_SPACE: q_item.op = asep_pkg::OP_NONE;
			default:            q_item.op = asep_pkg::OP_NONE;
		endcase
	end

endmodule

// ===== rtl/asep_queue.sv =====
module asep_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  asep_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output asep_pkg::item_t pop_item
);

	asep_pkg::item_t                 entries_q [asep_pkg::QUEUE_DEPTH];
	logic [asep_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [asep_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [asep_pkg::QCNT_W-1:0]     count_q;
	logic                            do_push;
	logic                            do_pop;

	assign push_ready = count_q != asep_pkg::QCNT_W'(asep_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/asep_ram.sv =====
module asep_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                            wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                            rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== rtl/asep_back.sv =====
module asep_back #(
	parameter int MAX_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_ready,
	input  asep_pkg::item_t     q_item,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  value,
	output logic                error
);

	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam logic [DW-1:0] DEPTH_FULL = DW'(MAX_DEPTH);

	logic [31:0]       num_q;
	logic [31:0]       sum_q;
	logic              sign_q;
	logic [DW-1:0]     depth_q;
	logic              err_q;
	asep_pkg::frame_t  tos_q;

	logic [31:0]       num_n;
	logic [31:0]       sum_n;
	logic              sign_n;
	logic [DW-1:0]     depth_n;
	logic              err_n;
	asep_pkg::frame_t  tos_n;

	logic [31:0]       folded;
	logic              fire;
	logic              wr_en;
	logic [AW-1:0]     rd_addr;
	logic [DW:0]       below;
	asep_pkg::frame_t  rd_frame;

	logic              out_valid_q;
	logic [31:0]       res_sum_q;
	logic [31:0]       res_num_q;
	logic              res_sign_q;
	logic              res_err_q;

	assign q_ready = !q_item.last || !out_valid_q || out_ready;
	assign fire    = q_valid && q_ready;
	assign folded  = sign_q ? (sum_q - num_q) : (sum_q + num_q);

	always_comb begin
		num_n   = num_q;
		sum_n   = sum_q;
		sign_n  = sign_q;
		depth_n = depth_q;
		err_n   = err_q;
		tos_n   = tos_q;
		wr_en   = 1'b0;
		if (fire) begin
			unique case (q_item.op) inside
				asep_pkg::OP_DIGIT: begin
					num_n = (num_q << 3) + (num_q << 1) + {28'd0, q_item.digit};
				end
				asep_pkg::OP_PLUS, asep_pkg::OP_MINUS: begin
					sum_n  = folded;
					num_n  = '0;
					sign_n = q_item.op == asep_pkg::OP_MINUS;
				end
				asep_pkg::OP_OPEN: begin
					if (depth_q != DEPTH_FULL) begin
						wr_en      = 1'b1;
						tos_n.sum  = sum_q;
						tos_n.sign = sign_q;
						depth_n    = depth_q + 1'b1;
					end else begin
						err_n = 1'b1;
					end
					sum_n  = '0;
					sign_n = 1'b0;
					num_n  = '0;
				end
				asep_pkg::OP_CLOSE: begin
					if (depth_q != '0) begin
						depth_n = depth_q - 1'b1;
						num_n   = folded;
						sum_n   = tos_q.sum;
						sign_n  = tos_q.sign;
						tos_n   = rd_frame;
					end else begin
						err_n  = 1'b1;
						sum_n  = folded;
						num_n  = '0;
						sign_n = 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// With two or more frames saved, the read port holds the frame just below the top of the stack.
	assign below   = {1'b0, depth_n} - (DW + 1)'(2);
	assign rd_addr = ({1'b0, depth_n} >= (DW + 1)'(2)) ? below[AW-1:0] : '0;

	asep_ram #(
		.WIDTH(asep_pkg::FRAME_W),
		.DEPTH(MAX_DEPTH)
	) u_stack (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(depth_q[AW-1:0]),
		.wr_data({sum_q, sign_q}),
		.rd_addr(rd_addr),
		.rd_data(rd_frame)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q       <= '0;
			sum_q       <= '0;
			sign_q      <= 1'b0;
			depth_q     <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire && q_item.last) begin
				num_q       <= '0;
				sum_q       <= '0;
				sign_q      <= 1'b0;
				depth_q     <= '0;
				err_q       <= 1'b0;
				out_valid_q <= 1'b1;
			end else begin
				num_q   <= num_n;
				sum_q   <= sum_n;
				sign_q  <= sign_n;
				depth_q <= depth_n;
				err_q   <= err_n;
				if (out_ready) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		tos_q <= tos_n;
		if (fire && q_item.last) begin
			res_sum_q  <= sum_n;
			res_num_q  <= num_n;
			res_sign_q <= sign_n;
			res_err_q  <= err_n || (depth_n != '0);
		end
	end

	assign out_valid = out_valid_q;
	assign value     = $signed(res_sign_q ? (res_sum_q - res_num_q) : (res_sum_q + res_num_q));
	assign error     = res_err_q;

endmodule

// ===== rtl/add_sub_paren_expression_eval.sv =====
// Evaluates an expression of decimal numbers, '+', '-' and parentheses that arrives
// one character per item, and returns one result (value and error) for the item
// marked is_last. Characters are taken at one per clock as long as results are
// drained; once its last character is accepted, a result passes through the queue
// and the execution unit's result registers before it can be taken. A decoder
// classifies each character into a four-item queue, and the execution unit, with
// its multiply-by-ten and fold adder, retires one queued item per cycle while no
// finished result waits to be taken. Open parentheses save frames in a
// MAX_DEPTH-entry memory with the top frame held in a register, so there is no
// clearing pass after reset. Values wrap modulo 2^32; error is set for nesting
// beyond MAX_DEPTH, an unmatched ')' or a '(' left open at the end.
module add_sub_paren_expression_eval #(
	parameter int MAX_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         char_code,
	input  logic               is_last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] value,
	output logic               error
);

	logic            push_valid;
	logic            push_ready;
	asep_pkg::item_t push_item;
	logic            pop_valid;
	logic            pop_ready;
	asep_pkg::item_t pop_item;

	asep_front u_front (
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.is_last(is_last),
		.q_valid(push_valid),
		.q_ready(push_ready),
		.q_item(push_item)
	);

	asep_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item(push_item),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item(pop_item)
	);

	asep_back #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(pop_valid),
		.q_ready(pop_ready),
		.q_item(pop_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value(value),
		.error(error)
	);

endmodule

// ===== rtl/asep_checker.sv =====
`include "add_sub_paren_expression_eval_defines.svh"

module asep_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] value,
	input logic        error
);

	`ASEP_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid, "Result shown during reset.")
	`ASEP_ASSERT_RUN(a_ready_when_drained, !out_valid |-> in_ready, "Input stalled with no result pending.")
	`ASEP_ASSERT_RUN(a_out_held, out_valid && !out_ready |=> out_valid, "Result withdrawn before taken.")
	`ASEP_ASSERT_RUN(a_out_stable, out_valid && !out_ready |=> $stable(value) && $stable(error), "Result changed while stalled.")

endmodule

bind add_sub_paren_expression_eval asep_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.value(value),
	.error(error)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

typedef struct {
	logic signed [31:0] value;
	logic               error;
} expr_result_t;

class expr_ledger;
	logic [31:0]       num_acc;
	logic [31:0]       level_sum;
	logic              neg_next;
	logic              bad;
	asep_pkg::frame_t  frames[$];
	int unsigned       nest_limit;
	expr_result_t      due[$];
	int                failures;
	int                checked;
	int                flagged;
	int                deepest;

	function new(int unsigned lim);
		nest_limit = lim;
		failures = 0;
		checked = 0;
		flagged = 0;
		deepest = 0;
		clear();
	endfunction

	function void clear();
		num_acc = '0;
		level_sum = '0;
		neg_next = 1'b0;
		bad = 1'b0;
		frames.delete();
	endfunction

	function logic [31:0] folded();
		return neg_next ? level_sum - num_acc : level_sum + num_acc;
	endfunction

	function void take_char(logic [7:0] c, logic last);
		logic [31:0]      inner;
		asep_pkg::frame_t fr;
		expr_result_t     r;
		if (c >= asep_pkg::CH_ZERO && c <= asep_pkg::CH_NINE) begin
			num_acc = num_acc * 32'd10 + {24'd0, c - asep_pkg::CH_ZERO};
		end else if (c == asep_pkg::CH_PLUS || c == asep_pkg::CH_MINUS) begin
			level_sum = folded();
			num_acc = '0;
			neg_next = (c == asep_pkg::CH_MINUS);
		end else if (c == asep_pkg::CH_OPEN) begin
			if (frames.size() < nest_limit) begin
				fr.sum = level_sum;
				fr.sign = neg_next;
				frames.push_back(fr);
				if (frames.size() > deepest)
					deepest = frames.size();
			end else begin
				bad = 1'b1;
			end
			level_sum = '0;
			neg_next = 1'b0;
			num_acc = '0;
		end else if (c == asep_pkg::CH_CLOSE) begin
			inner = folded();
			if (frames.size() > 0) begin
				fr = frames.pop_back();
				num_acc = inner;
				level_sum = fr.sum;
				neg_next = fr.sign;
			end else begin
				bad = 1'b1;
				level_sum = inner;
				num_acc = '0;
				neg_next = 1'b0;
			end
		end
		if (last) begin
			r.value = folded();
			r.error = bad || (frames.size() != 0);
			due.push_back(r);
			clear();
		end
	endfunction

	function void check_result(logic signed [31:0] v, logic e);
		expr_result_t r;
		if (due.size() == 0) begin
			$error("unexpected result: value %0d error %0b", v, e);
			failures++;
			return;
		end
		r = due[0];
		due.delete(0);
		if (v !== r.value) begin
			$error("value: expected %0d, got %0d", r.value, v);
			failures++;
		end
		if (e !== r.error) begin
			$error("error: expected %0b, got %0b", r.error, e);
			failures++;
		end
		checked++;
		if (r.error)
			flagged++;
	endfunction

	function int outstanding();
		return due.size();
	endfunction
endclass

module tb;
	localparam int NEST_LIMIT = 16;
	localparam int RANDOM_CHARS = 1450;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         char_code = '0;
	logic               is_last = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] value;
	logic               error;

	expr_ledger ledger;
	logic [7:0] expr_chars[$];
	bit         tx_quiet = 1'b0;
	bit         rx_quiet = 1'b0;
	int         sent_chars = 0;
	int         expr_count = 0;

	add_sub_paren_expression_eval #(
		.MAX_DEPTH(NEST_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.is_last(is_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value(value),
		.error(error)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				ledger.take_char(char_code, is_last);
			if (out_valid && out_ready)
				ledger.check_result(value, error);
		end
	end

	function automatic void load_text(input string s);
		for (int i = 0; i < s.len(); i++)
			expr_chars.push_back(s[i]);
	endfunction

	function automatic void put_number();
		int ndig;
		ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
		repeat (ndig)
			expr_chars.push_back(asep_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
	endfunction

	function automatic void put_sign();
		expr_chars.push_back($urandom_range(0, 1) ? asep_pkg::CH_PLUS : asep_pkg::CH_MINUS);
	endfunction

	// Mostly balanced expressions; a few are left open, carry stray ')' or noise bytes,
	// and some nest past the frame limit.
	task automatic build_expr();
		bit deep;
		bit broken;
		int maxd;
		int d;
		int steps;
		int r;
		deep = ($urandom_range(0, 11) == 0);
		broken = ($urandom_range(0, 7) == 0);
		maxd = deep ? $urandom_range(NEST_LIMIT - 2, NEST_LIMIT + 2) : $urandom_range(1, 4);
		d = 0;
		if (deep) begin
			for (int k = 0; k < maxd; k++) begin
				if ($urandom_range(0, 1)) begin
					put_number();
					put_sign();
				end
				expr_chars.push_back(asep_pkg::CH_OPEN);
			end
			d = maxd;
		end
		steps = $urandom_range(1, 20);
		repeat (steps) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				put_number();
			end else if (r < 55) begin
				put_sign();
			end else if (r < 70) begin
				if (d < maxd) begin
					expr_chars.push_back(asep_pkg::CH_OPEN);
					d++;
				end else begin
					put_number();
				end
			end else if (r < 85) begin
				if (d > 0) begin
					expr_chars.push_back(asep_pkg::CH_CLOSE);
					d--;
				end else begin
					put_sign();
				end
			end else if (r < 91) begin
				expr_chars.push_back(asep_pkg::CH_SPACE);
			end else if (r < 95) begin
				expr_chars.push_back(8'($urandom_range(0, 255)));
			end else if (r < 97) begin
				expr_chars.push_back(asep_pkg::CH_CLOSE);
				if (d > 0)
					d--;
			end else begin
				put_number();
			end
		end
		if (!broken) begin
			while (d > 0) begin
				if ($urandom_range(0, 2) == 0) begin
					put_sign();
					put_number();
				end
				expr_chars.push_back(asep_pkg::CH_CLOSE);
				d--;
			end
		end
	endtask

	task automatic send_expr();
		int gap;
		for (int i = 0; i < expr_chars.size(); i++) begin
			gap = tx_quiet ? 0 : $urandom_range(0, 17);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			in_valid <= 1'b1;
			char_code <= expr_chars[i];
			is_last <= (i == expr_chars.size() - 1);
			@(posedge clk);
			while (!in_ready)
				@(posedge clk);
			@(negedge clk);
		end
		sent_chars += expr_chars.size();
		expr_count++;
		expr_chars.delete();
	endtask

	initial begin
		int gap;
		wait (arst_n);
		@(negedge clk);
		forever begin
			gap = rx_quiet ? 0 : $urandom_range(0, 17);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	initial begin
		int directed_chars;
		arst_n <= 1'b0;
		ledger = new(NEST_LIMIT);
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Digit after ')', an unmatched ')', ignored bytes and a '(' left open at the end.
		load_text("(7)5 -)3");
		expr_chars.push_back(8'hff);
		expr_chars.push_back(8'h00);
		expr_chars.push_back(asep_pkg::CH_OPEN);
		send_expr();
		load_text("2147483647+1");
		send_expr();
		expr_chars.push_back(asep_pkg::CH_CLOSE);
		send_expr();
		directed_chars = sent_chars;

		while (sent_chars - directed_chars < RANDOM_CHARS) begin
			tx_quiet = ($urandom_range(0, 4) == 0);
			rx_quiet = ($urandom_range(0, 4) == 0);
			build_expr();
			if (expr_chars.size() == 0)
				put_number();
			send_expr();
		end
		in_valid <= 1'b0;
		is_last <= 1'b0;

		while (ledger.outstanding() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("tb: %0d characters in %0d expressions, %0d results checked, %0d with error set",
			sent_chars, expr_count, ledger.checked, ledger.flagged);
		$display("tb: deepest nesting reached %0d of %0d frames", ledger.deepest, NEST_LIMIT);
		if (ledger.failures == 0 && ledger.outstanding() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb: FAIL");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/asep_pkg.sv
rtl/asep_front.sv
rtl/asep_queue.sv
rtl/asep_ram.sv
rtl/asep_back.sv
rtl/add_sub_paren_expression_eval.sv
rtl/asep_checker.sv
verif/tb.sv
